FILE: rtl/core/fsrf_pkg.sv
// fsrf_pkg: shared types and codes of the frame slot ring FIFO.
// No dependencies; used by frame_slot_ring_fifo_core.
`default_nettype none

package fsrf_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_STREAM
    } state_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_DROP  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;
    localparam status_t STATUS_TRUNC = 2'd3;

    // operation codes of an item word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // register indexes of the configuration port
    localparam logic REG_SLOTS = 1'b0;
    localparam logic REG_SIZE  = 1'b1;

    localparam int SLOTS_CFG_W = 5;
    localparam int SIZE_CFG_W  = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int STORED_W    = 5;

    localparam logic [SLOTS_CFG_W-1:0] SLOTS_RESET = 5'd16;
    localparam logic [SIZE_CFG_W-1:0]  SIZE_RESET  = 7'd64;
    localparam logic [STORED_W-1:0]    STORED_MAX  = 5'd31;

endpackage

`default_nettype wire

FILE: rtl/core/fsrf_ram.sv
// fsrf_ram: generic simple dual-port RAM, one write port, one read port
// with registered read data (held while no read is issued). No dependencies.
`default_nettype none

module fsrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wen,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     ren,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/frame_slot_ring_fifo_core.sv
// frame_slot_ring_fifo_core: ring of fixed-size frame slots with stored lengths.
// Depends on fsrf_pkg (types, codes) and fsrf_ram (frame bytes, slot lengths).
`default_nettype none
//
//  channel   handshake                 words
//  -------   -----------------------   ---------------------------------------
//  item      item_valid / item_stall   func, data_in, frame_end
//  result    result_valid / result_s.  status, data_out, last_byte, frame_length
//  config    cfg_wen (no back-pressure) cfg_index, cfg_data
//
//  Write words are taken in the idle state with no setup; a frame-end word or
//  a read that wraps a pointer past a shrunken ring stalls the item side while
//  the further wrap steps run, one subtraction each, until the wrap state is left.
//  A read first sets up (length RAM read, length capture, first byte read), then
//  one result word per cycle, paced by the single frame RAM read port and result_stall.
//  Reset is asynchronous, active low; both RAMs are left unset (no clearing pass).
//  Result stall back-pressures the item side; a read skid keeps the RAM data.

module frame_slot_ring_fifo_core #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_BYTES = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // item channel
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic                              func,
    input  wire logic [fsrf_pkg::BYTE_W-1:0]       data_in,
    input  wire logic                              frame_end,
    // result channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output fsrf_pkg::status_t                      status,
    output logic      [fsrf_pkg::BYTE_W-1:0]       data_out,
    output logic                                   last_byte,
    output logic      [fsrf_pkg::LEN_W-1:0]        frame_length,
    // configuration port
    input  wire logic                              cfg_wen,
    input  wire logic                              cfg_index,
    input  wire logic [fsrf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // slot index, pointer compare width, fill/length width, frame RAM address
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = (IW + 1 > fsrf_pkg::SLOTS_CFG_W) ? IW + 1 : fsrf_pkg::SLOTS_CFG_W;
    localparam int FW = $clog2(SLOT_BYTES + 1);
    localparam int AW = $clog2(SLOT_COUNT * SLOT_BYTES);

    // ---------------------------------------------------------------- state
    fsrf_pkg::state_t state_reg, state_next;

    logic [fsrf_pkg::SLOTS_CFG_W-1:0] slots_cfg_reg;
    logic [fsrf_pkg::SIZE_CFG_W-1:0]  size_cfg_reg;

    logic [IW-1:0] wr_slot_reg, wr_slot_next;
    logic [IW-1:0] rd_slot_reg, rd_slot_next;
    logic          wr_wrap_reg, wr_wrap_next;   // write pointer may still exceed ring
    logic          rd_wrap_reg, rd_wrap_next;
    logic [fsrf_pkg::STORED_W-1:0] stored_reg, stored_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          drop_reg, drop_next;
    logic          trunc_reg, trunc_next;

    // read sequencer
    logic [IW-1:0] cur_slot_reg, cur_slot_next;
    logic [FW-1:0] len_reg, len_next;
    logic [FW-1:0] issue_cnt_reg, issue_cnt_next;
    logic [FW-1:0] emit_cnt_reg, emit_cnt_next;
    logic          pend_reg, pend_next;         // frame RAM output holds an unsent byte

    // output register
    logic                            out_valid_reg, out_valid_next;
    fsrf_pkg::status_t               status_reg, status_next;
    logic [fsrf_pkg::BYTE_W-1:0]     data_reg, data_next;
    logic                            last_reg, last_next;
    logic [fsrf_pkg::LEN_W-1:0]      flen_reg, flen_next;

    // RAM ports
    logic                        fram_wen, fram_ren;
    logic [AW-1:0]               fram_waddr, fram_raddr;
    logic [fsrf_pkg::BYTE_W-1:0] fram_rdata;
    logic                        lram_wen, lram_ren;
    logic [IW-1:0]               lram_waddr;
    logic [FW-1:0]               lram_wdata, lram_rdata;

    // ---------------------------------------------------------- effective cfg
    logic [CW-1:0] slots_eff;
    logic [fsrf_pkg::SIZE_CFG_W-1:0] size_eff;

    always_comb
    begin
        if (slots_cfg_reg == '0)
            slots_eff = CW'(1);
        else if (CW'(slots_cfg_reg) > CW'(SLOT_COUNT))
            slots_eff = CW'(SLOT_COUNT);
        else
            slots_eff = CW'(slots_cfg_reg);

        if (size_cfg_reg == '0)
            size_eff = fsrf_pkg::SIZE_CFG_W'(1);
        else if (size_cfg_reg > fsrf_pkg::SIZE_CFG_W'(SLOT_BYTES))
            size_eff = fsrf_pkg::SIZE_CFG_W'(SLOT_BYTES);
        else
            size_eff = size_cfg_reg;
    end

    // ------------------------------------------------------------ handshake
    logic out_free, item_acc, consume, last_emit;

    assign out_free   = !out_valid_reg || !result_stall;
    assign item_stall = !((state_reg == fsrf_pkg::ST_IDLE) && !wr_wrap_reg
                          && !rd_wrap_reg && out_free);
    assign item_acc   = item_valid && !item_stall;
    assign consume    = (state_reg == fsrf_pkg::ST_STREAM) && pend_reg && out_free;
    assign last_emit  = (emit_cnt_reg + FW'(1)) == len_reg;

    // pointer advance: (p + 1) mod slots, first subtract here, rest in later cycles
    logic [CW-1:0] wr_inc, rd_inc;
    assign wr_inc = CW'(wr_slot_reg) + CW'(1);
    assign rd_inc = CW'(rd_slot_reg) + CW'(1);

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fsrf_pkg::ST_IDLE:
            begin
                if (item_acc && (func == fsrf_pkg::FUNC_READ) && (stored_reg != '0))
                    state_next = fsrf_pkg::ST_LEN;
            end
            fsrf_pkg::ST_LEN:
            begin
                state_next = fsrf_pkg::ST_STREAM;
            end
            fsrf_pkg::ST_STREAM:
            begin
                if (consume && last_emit)
                    state_next = fsrf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsrf_pkg::ST_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------- datapath/outputs
    logic          start_drop;
    logic [FW-1:0] len_clamped;

    assign start_drop = !drop_reg && (fill_reg == '0)
                        && (CW'(stored_reg) >= slots_eff);

    always_comb
    begin
        if (lram_rdata == '0)
            len_clamped = FW'(1);
        else if (lram_rdata > FW'(SLOT_BYTES))
            len_clamped = FW'(SLOT_BYTES);
        else
            len_clamped = lram_rdata;
    end

    always_comb
    begin
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        wr_wrap_next   = wr_wrap_reg;
        rd_wrap_next   = rd_wrap_reg;
        stored_next    = stored_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        trunc_next     = trunc_reg;
        cur_slot_next  = cur_slot_reg;
        len_next       = len_reg;
        issue_cnt_next = issue_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && result_stall;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        flen_next      = flen_reg;

        fram_wen   = 1'b0;
        fram_waddr = AW'(wr_slot_reg) * AW'(SLOT_BYTES) + AW'(fill_reg);
        fram_ren   = 1'b0;
        fram_raddr = AW'(cur_slot_reg) * AW'(SLOT_BYTES) + AW'(issue_cnt_reg);
        lram_wen   = 1'b0;
        lram_waddr = wr_slot_reg;
        lram_wdata = fill_reg;
        lram_ren   = 1'b0;

        // leftover wrap steps after a ring shrink
        if (wr_wrap_reg)
        begin
            if (CW'(wr_slot_reg) >= slots_eff)
                wr_slot_next = IW'(CW'(wr_slot_reg) - slots_eff);
            else
                wr_wrap_next = 1'b0;
        end
        if (rd_wrap_reg)
        begin
            if (CW'(rd_slot_reg) >= slots_eff)
                rd_slot_next = IW'(CW'(rd_slot_reg) - slots_eff);
            else
                rd_wrap_next = 1'b0;
        end

        if (item_acc && (func == fsrf_pkg::FUNC_WRITE))
        begin
            // write word: one frame byte unless dropped or slot full; single result
            out_valid_next = 1'b1;
            data_next      = '0;
            last_next      = 1'b1;
            flen_next      = '0;
            if (drop_reg || start_drop)
            begin
                status_next = fsrf_pkg::STATUS_DROP;
                drop_next   = !frame_end;
            end
            else
            begin
                status_next = fsrf_pkg::STATUS_OK;
                if (fsrf_pkg::SIZE_CFG_W'(fill_reg) < size_eff)
                begin
                    fram_wen  = 1'b1;
                    fill_next = fill_reg + FW'(1);
                end
                else
                begin
                    trunc_next  = 1'b1;
                    status_next = fsrf_pkg::STATUS_TRUNC;
                end
                if (frame_end)
                begin
                    if (trunc_reg)
                        status_next = fsrf_pkg::STATUS_TRUNC;
                    lram_wen   = 1'b1;
                    lram_wdata = fill_next;
                    if (wr_inc >= slots_eff)
                    begin
                        wr_slot_next = IW'(wr_inc - slots_eff);
                        wr_wrap_next = (wr_inc - slots_eff) >= slots_eff;
                    end
                    else
                    begin
                        wr_slot_next = IW'(wr_inc);
                    end
                    if (stored_reg != fsrf_pkg::STORED_MAX)
                        stored_next = stored_reg + fsrf_pkg::STORED_W'(1);
                    fill_next  = '0;
                    trunc_next = 1'b0;
                end
            end
        end
        else if (item_acc && (func == fsrf_pkg::FUNC_READ))
        begin
            if (stored_reg == '0)
            begin
                out_valid_next = 1'b1;
                status_next    = fsrf_pkg::STATUS_EMPTY;
                data_next      = '0;
                last_next      = 1'b1;
                flen_next      = '0;
            end
            else
            begin
                // fetch the length, free the slot now
                lram_ren      = 1'b1;
                cur_slot_next = rd_slot_reg;
                issue_cnt_next = '0;
                emit_cnt_next = '0;
                pend_next     = 1'b0;
                stored_next   = stored_reg - fsrf_pkg::STORED_W'(1);
                if (rd_inc >= slots_eff)
                begin
                    rd_slot_next = IW'(rd_inc - slots_eff);
                    rd_wrap_next = (rd_inc - slots_eff) >= slots_eff;
                end
                else
                begin
                    rd_slot_next = IW'(rd_inc);
                end
            end
        end

        if (state_reg == fsrf_pkg::ST_LEN)
        begin
            len_next = len_clamped;
        end

        if (state_reg == fsrf_pkg::ST_STREAM)
        begin
            if (consume)
            begin
                out_valid_next = 1'b1;
                status_next    = fsrf_pkg::STATUS_OK;
                data_next      = fram_rdata;
                last_next      = last_emit;
                flen_next      = fsrf_pkg::LEN_W'(len_reg);
                emit_cnt_next  = emit_cnt_reg + FW'(1);
            end
            // keep one byte in flight; RAM output holds while not reading
            if ((issue_cnt_reg < len_reg) && (!pend_reg || consume))
            begin
                fram_ren       = 1'b1;
                issue_cnt_next = issue_cnt_reg + FW'(1);
                pend_next      = 1'b1;
            end
            else if (consume)
            begin
                pend_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsrf_pkg::ST_IDLE;
            slots_cfg_reg <= fsrf_pkg::SLOTS_RESET;
            size_cfg_reg  <= fsrf_pkg::SIZE_RESET;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            wr_wrap_reg   <= 1'b0;
            rd_wrap_reg   <= 1'b0;
            stored_reg    <= '0;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            trunc_reg     <= 1'b0;
            issue_cnt_reg <= '0;
            emit_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wen && (cfg_index == fsrf_pkg::REG_SLOTS))
                slots_cfg_reg <= cfg_data[fsrf_pkg::SLOTS_CFG_W-1:0];
            if (cfg_wen && (cfg_index == fsrf_pkg::REG_SIZE))
                size_cfg_reg <= cfg_data[fsrf_pkg::SIZE_CFG_W-1:0];
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            wr_wrap_reg   <= wr_wrap_next;
            rd_wrap_reg   <= rd_wrap_next;
            stored_reg    <= stored_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            trunc_reg     <= trunc_next;
            issue_cnt_reg <= issue_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        len_reg      <= len_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        flen_reg     <= flen_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign data_out     = data_reg;
    assign last_byte    = last_reg;
    assign frame_length = flen_reg;

    // ------------------------------------------------------------- memories
    fsrf_ram #(
        .WIDTH (fsrf_pkg::BYTE_W),
        .DEPTH (SLOT_COUNT * SLOT_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .wen   (fram_wen),
        .waddr (fram_waddr),
        .wdata (data_in),
        .ren   (fram_ren),
        .raddr (fram_raddr),
        .rdata (fram_rdata)
    );

    fsrf_ram #(
        .WIDTH (FW),
        .DEPTH (SLOT_COUNT)
    ) u_len_ram (
        .clk   (clk),
        .wen   (lram_wen),
        .waddr (lram_waddr),
        .wdata (lram_wdata),
        .ren   (lram_ren),
        .raddr (rd_slot_reg),
        .rdata (lram_rdata)
    );

    // ----------------------------------------------------------- assertions
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> (state_reg == fsrf_pkg::ST_IDLE))
        else $error("item taken while sequencer busy");

    a_stream_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fsrf_pkg::ST_STREAM)
            |-> (issue_cnt_reg == (emit_cnt_reg + FW'(pend_reg))))
        else $error("frame RAM reads out of step with emitted words");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fsrf_pkg::ST_STREAM) |-> (issue_cnt_reg <= len_reg))
        else $error("read past stored frame length");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        fram_wen |-> ((state_reg == fsrf_pkg::ST_IDLE) && !fram_ren))
        else $error("frame write during a read");

endmodule

`default_nettype wire
